// ===== hdl/cpa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the page allocator.
package cpa_pkg;

  localparam int TABLE_PAGES  = 1024;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;

  localparam int PAGE_W     = $clog2(TABLE_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int STEP_W     = PAGE_W + 2;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int BYTES_W    = 22;
  localparam int STATUS_W   = 3;

  localparam int IN_USED  = BYTES_W + PAGE_W + CNT_W;
  localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_USED = STATUS_W + PAGE_W + CNT_W + CNT_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  // Page table entry: bit 1 free, bit 0 referenced.
  localparam logic [1:0] ENT_FREE    = 2'b10;
  localparam logic [1:0] ENT_ALLOC   = 2'b00;
  localparam logic [1:0] ENT_CLAIMED = 2'b01;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_LARGE     = 3'd2,
    ST_NO_RUN    = 3'd3,
    ST_NO_VICTIM = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FREE_STEP,
    OP_FREE_END,
    OP_SET_ZERO,
    OP_SET_LARGE,
    OP_RECL_INIT,
    OP_RECL_RD,
    OP_RECL_EV,
    OP_RECL_FAIL,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_SCAN_FAIL,
    OP_CLAIM_INIT,
    OP_CLAIM_STEP,
    OP_CLAIM_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic clear_last;
    logic free_req;
    logic req_zero;
    logic req_large;
    logic need_gt_free;
    logic free_done;
    logic sweep_done;
    logic victim;
    logic scan_end;
    logic run_found;
    logic count_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hdl/cpa_dpath.sv =====
// Datapath of the page allocator: page table memory, counters, request and result registers.
module cpa_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cpa_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [cpa_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tuser,
  input  cpa_pkg::op_t              op,
  output cpa_pkg::dp_status_t       st,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [cpa_pkg::OUT_W-1:0] m_tdata
);

  logic [1:0] mem [cpa_pkg::TABLE_PAGES];
  logic [1:0] rd_data;

  logic [cpa_pkg::CNT_W-1:0]  pool_pages;
  logic [cpa_pkg::CNT_W-1:0]  pool_eff;
  logic [cpa_pkg::CNT_W-1:0]  free_count;
  logic [cpa_pkg::PAGE_W-1:0] hand;
  logic [cpa_pkg::CNT_W-1:0]  ptr;
  logic [cpa_pkg::STEP_W-1:0] steps;
  logic [cpa_pkg::CNT_W-1:0]  need;
  logic [cpa_pkg::CNT_W-1:0]  tally;
  logic [cpa_pkg::CNT_W-1:0]  remaining;
  logic [cpa_pkg::PAGE_W-1:0] run_start;
  logic                       req_free;
  logic                       req_zero;
  logic                       req_large;

  cpa_pkg::status_t           res_status;
  logic [cpa_pkg::PAGE_W-1:0] res_start;
  logic [cpa_pkg::CNT_W-1:0]  res_len;
  logic [cpa_pkg::CNT_W-1:0]  evicted;
  logic [cpa_pkg::OUT_W-1:0]  out_data;
  logic                       out_valid;

  logic [cpa_pkg::BYTES_W-1:0] in_bytes;
  logic [cpa_pkg::PAGE_W-1:0]  in_start;
  logic [cpa_pkg::CNT_W-1:0]   in_count;
  logic [cpa_pkg::BYTES_W:0]   need_sum;
  logic [cpa_pkg::CNT_W:0]     ptr_inc;
  logic [cpa_pkg::CNT_W-1:0]   next_page;
  logic [cpa_pkg::CNT_W:0]     free_sum;
  logic                        mem_we;
  logic                        mem_re;
  logic [1:0]                  mem_wdata;

  assign in_bytes = s_tdata[cpa_pkg::BYTES_W-1:0];
  assign in_start = s_tdata[cpa_pkg::BYTES_W +: cpa_pkg::PAGE_W];
  assign in_count = s_tdata[cpa_pkg::BYTES_W + cpa_pkg::PAGE_W +: cpa_pkg::CNT_W];
  assign need_sum = {1'b0, in_bytes}
                  + (cpa_pkg::BYTES_W+1)'(cpa_pkg::HEADER_BYTES + cpa_pkg::PAGE_BYTES - 1);

  always_comb begin
    if (pool_pages == '0) begin
      pool_eff = cpa_pkg::CNT_W'(1);
    end else if (pool_pages > cpa_pkg::CNT_W'(cpa_pkg::TABLE_PAGES)) begin
      pool_eff = cpa_pkg::CNT_W'(cpa_pkg::TABLE_PAGES);
    end else begin
      pool_eff = pool_pages;
    end
  end

  // Clock hand advance with wrap at the pool edge.
  assign ptr_inc   = {1'b0, ptr} + (cpa_pkg::CNT_W+1)'(1);
  assign next_page = (ptr_inc >= {1'b0, pool_eff}) ? '0 : ptr_inc[cpa_pkg::CNT_W-1:0];
  assign free_sum  = {1'b0, free_count} + {1'b0, tally};

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = cpa_pkg::ENT_FREE;
    case (op)
      cpa_pkg::OP_CLEAR, cpa_pkg::OP_FREE_STEP: begin
        mem_we = 1'b1;
      end
      cpa_pkg::OP_RECL_EV: begin
        mem_we    = !rd_data[1];
        mem_wdata = st.victim ? cpa_pkg::ENT_FREE : cpa_pkg::ENT_ALLOC;
      end
      cpa_pkg::OP_CLAIM_STEP: begin
        mem_we    = 1'b1;
        mem_wdata = cpa_pkg::ENT_CLAIMED;
      end
      cpa_pkg::OP_RECL_RD, cpa_pkg::OP_SCAN_RD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr[cpa_pkg::PAGE_W-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[ptr[cpa_pkg::PAGE_W-1:0]];
    end
  end

  always_comb begin
    st.clear_last   = (ptr == cpa_pkg::CNT_W'(cpa_pkg::TABLE_PAGES - 1));
    st.free_req     = req_free;
    st.req_zero     = req_zero;
    st.req_large    = req_large;
    st.need_gt_free = (need > free_count);
    st.free_done    = (remaining == '0) || (ptr >= pool_eff);
    st.sweep_done   = (steps == {pool_eff, 1'b0});
    st.victim       = !rd_data[1] && !rd_data[0];
    st.scan_end     = (ptr >= pool_eff);
    st.run_found    = rd_data[1] && (({1'b0, tally} + (cpa_pkg::CNT_W+1)'(1)) == {1'b0, need});
    st.count_done   = (remaining == '0);
    st.out_busy     = out_valid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= cpa_pkg::CNT_W'(cpa_pkg::TABLE_PAGES);
      free_count <= cpa_pkg::CNT_W'(cpa_pkg::TABLE_PAGES);
      hand       <= '0;
      ptr        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_pages <= cfg_wdata;
      end
      if (op == cpa_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (op)
        cpa_pkg::OP_CLEAR: begin
          ptr <= ptr_inc[cpa_pkg::CNT_W-1:0];
        end
        cpa_pkg::OP_LOAD: begin
          ptr <= {1'b0, in_start};
        end
        cpa_pkg::OP_FREE_STEP, cpa_pkg::OP_CLAIM_STEP, cpa_pkg::OP_SCAN_EV: begin
          ptr <= ptr_inc[cpa_pkg::CNT_W-1:0];
        end
        cpa_pkg::OP_FREE_END: begin
          if (free_sum > {1'b0, pool_eff}) begin
            free_count <= pool_eff;
          end else begin
            free_count <= free_sum[cpa_pkg::CNT_W-1:0];
          end
        end
        cpa_pkg::OP_RECL_INIT: begin
          ptr <= ({1'b0, hand} >= pool_eff) ? '0 : {1'b0, hand};
        end
        cpa_pkg::OP_RECL_EV: begin
          if (st.victim) begin
            hand <= next_page[cpa_pkg::PAGE_W-1:0];
            if (free_count < pool_eff) begin
              free_count <= free_count + cpa_pkg::CNT_W'(1);
            end
          end else begin
            ptr <= next_page;
          end
        end
        cpa_pkg::OP_RECL_FAIL: begin
          hand <= ptr[cpa_pkg::PAGE_W-1:0];
        end
        cpa_pkg::OP_SCAN_INIT: begin
          ptr <= '0;
        end
        cpa_pkg::OP_CLAIM_INIT: begin
          ptr <= {1'b0, run_start};
        end
        cpa_pkg::OP_CLAIM_END: begin
          free_count <= (free_count >= need) ? free_count - need : '0;
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  // Payload and working registers, no reset needed.
  always_ff @(posedge clk) begin
    case (op)
      cpa_pkg::OP_LOAD: begin
        req_free   <= s_tuser;
        req_zero   <= (in_bytes == '0);
        req_large  <= ({1'b0, in_bytes} >= {pool_eff, cpa_pkg::PAGE_SHIFT'(0)});
        need       <= need_sum[cpa_pkg::BYTES_W:cpa_pkg::PAGE_SHIFT];
        remaining  <= in_count;
        tally      <= '0;
        res_status <= cpa_pkg::ST_OK;
        res_start  <= '0;
        res_len    <= '0;
        evicted    <= '0;
      end
      cpa_pkg::OP_FREE_STEP: begin
        remaining <= remaining - cpa_pkg::CNT_W'(1);
        tally     <= tally + cpa_pkg::CNT_W'(1);
      end
      cpa_pkg::OP_SET_ZERO:  res_status <= cpa_pkg::ST_ZERO;
      cpa_pkg::OP_SET_LARGE: res_status <= cpa_pkg::ST_LARGE;
      cpa_pkg::OP_RECL_INIT: steps <= '0;
      cpa_pkg::OP_RECL_EV: begin
        if (st.victim) begin
          evicted <= evicted + cpa_pkg::CNT_W'(1);
        end else begin
          steps <= steps + cpa_pkg::STEP_W'(1);
        end
      end
      cpa_pkg::OP_RECL_FAIL: res_status <= cpa_pkg::ST_NO_VICTIM;
      cpa_pkg::OP_SCAN_INIT: tally <= '0;
      cpa_pkg::OP_SCAN_EV: begin
        if (rd_data[1]) begin
          tally <= tally + cpa_pkg::CNT_W'(1);
          if (tally == '0) begin
            run_start <= ptr[cpa_pkg::PAGE_W-1:0];
          end
        end else begin
          tally <= '0;
        end
      end
      cpa_pkg::OP_SCAN_FAIL:  res_status <= cpa_pkg::ST_NO_RUN;
      cpa_pkg::OP_CLAIM_INIT: remaining <= need;
      cpa_pkg::OP_CLAIM_STEP: remaining <= remaining - cpa_pkg::CNT_W'(1);
      cpa_pkg::OP_CLAIM_END: begin
        res_start <= run_start;
        res_len   <= need;
      end
      cpa_pkg::OP_EMIT: begin
        out_data <= cpa_pkg::OUT_W'({evicted, res_len, res_start, res_status});
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== hdl/cpa_ctrl.sv =====
// Controller state machine of the page allocator: sequences clear, free, sweep, scan and claim.
module cpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  cpa_pkg::dp_status_t st,
  output cpa_pkg::op_t        op
);

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b000000000001,
    S_IDLE       = 12'b000000000010,
    S_CHECK      = 12'b000000000100,
    S_FREE       = 12'b000000001000,
    S_RECL_CHK   = 12'b000000010000,
    S_RECL_RD    = 12'b000000100000,
    S_RECL_EV    = 12'b000001000000,
    S_SCAN_RD    = 12'b000010000000,
    S_SCAN_EV    = 12'b000100000000,
    S_CLAIM_INIT = 12'b001000000000,
    S_CLAIM      = 12'b010000000000,
    S_DONE       = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = cpa_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = cpa_pkg::OP_CLEAR;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          op         = cpa_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.free_req) begin
          state_next = S_FREE;
        end else if (st.req_zero) begin
          op         = cpa_pkg::OP_SET_ZERO;
          state_next = S_DONE;
        end else if (st.req_large) begin
          op         = cpa_pkg::OP_SET_LARGE;
          state_next = S_DONE;
        end else begin
          state_next = S_RECL_CHK;
        end
      end
      S_FREE: begin
        if (st.free_done) begin
          op         = cpa_pkg::OP_FREE_END;
          state_next = S_DONE;
        end else begin
          op = cpa_pkg::OP_FREE_STEP;
        end
      end
      S_RECL_CHK: begin
        if (st.need_gt_free) begin
          op         = cpa_pkg::OP_RECL_INIT;
          state_next = S_RECL_RD;
        end else begin
          op         = cpa_pkg::OP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end
      end
      S_RECL_RD: begin
        if (st.sweep_done) begin
          op         = cpa_pkg::OP_RECL_FAIL;
          state_next = S_DONE;
        end else begin
          op         = cpa_pkg::OP_RECL_RD;
          state_next = S_RECL_EV;
        end
      end
      S_RECL_EV: begin
        op         = cpa_pkg::OP_RECL_EV;
        state_next = st.victim ? S_RECL_CHK : S_RECL_RD;
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          op         = cpa_pkg::OP_SCAN_FAIL;
          state_next = S_DONE;
        end else begin
          op         = cpa_pkg::OP_SCAN_RD;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        op         = cpa_pkg::OP_SCAN_EV;
        state_next = st.run_found ? S_CLAIM_INIT : S_SCAN_RD;
      end
      S_CLAIM_INIT: begin
        op         = cpa_pkg::OP_CLAIM_INIT;
        state_next = S_CLAIM;
      end
      S_CLAIM: begin
        if (st.count_done) begin
          op         = cpa_pkg::OP_CLAIM_END;
          state_next = S_DONE;
        end else begin
          op = cpa_pkg::OP_CLAIM_STEP;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          op         = cpa_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/contiguous_page_allocator_clock_core.sv =====
// Top level of the contiguous page allocator with clock replacement.
// Usage:
//   Requests enter on the s_ group; s_tuser selects allocate (0) or free (1).
//   An allocate turns byte_count plus the header into whole pages, reclaims
//   pages with the clock hand while the free count is short, then claims the
//   lowest contiguous run of free pages. A free marks a run free again.
//   One result per request leaves on the m_ group.
//   cfg_we/cfg_wdata write the pool size; write it only while idle.
// Operation:
//   One request is in work at a time; s_tready is high only while idle,
//   which starts the cycle after a result is loaded.
//   A free writes each page of its run free in turn. A zero or oversize
//   allocate is answered from the size check alone. An allocate reclaims
//   pages while the free count is short (the clock hand visits at most
//   2 x pool pages per reclaim), scans first fit from page 0, then claims the run.
//   The page table is a single-port memory, one access per cycle with a registered read.
// Reset: rst clears the control state, then every page table entry is
//   written free, one after another, before the first request is taken.
// Stall: a finished result waits in the output register while m_tready is
//   low; the next request is still taken and worked on, and its result
//   holds in the datapath result registers until the output register frees up.
module contiguous_page_allocator_clock_core (
  input  logic                      clk,
  input  logic                      rst,
  // pool_pages
  input  logic                      cfg_we,
  input  logic [cpa_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // byte_count[21:0], start_page[31:22], page_count[42:32], zero fill
  input  logic [cpa_pkg::IN_W-1:0]  s_tdata,
  // mode: 0 allocate, 1 free
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[2:0], run_start[12:3], run_length[23:13], evicted[34:24], zero fill
  output logic [cpa_pkg::OUT_W-1:0] m_tdata
);

  cpa_pkg::dp_status_t st;
  cpa_pkg::op_t        op;

  // Sequence each request through the datapath one command a cycle.
  cpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .op       (op)
  );

  // Hold the page table, counters, clock hand and output register.
  cpa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .op        (op),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== hdl/cpa_checker.sv =====
// Port-level assertions for the page allocator and their bind to the top level.
module cpa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [cpa_pkg::OUT_W-1:0] m_tdata
);

  logic [2:0]  r_status;
  logic [9:0]  r_start;
  logic [10:0] r_len;
  logic [10:0] r_evicted;

  assign r_status  = m_tdata[2:0];
  assign r_start   = m_tdata[12:3];
  assign r_len     = m_tdata[23:13];
  assign r_evicted = m_tdata[34:24];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_fail_no_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r_status != cpa_pkg::ST_OK |-> r_len == '0 && r_start == '0)
    else $error("failed request reports a run");

  a_early_fail_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_status == cpa_pkg::ST_ZERO || r_status == cpa_pkg::ST_LARGE)
    |-> r_evicted == '0)
    else $error("size check failure reports evictions");

  a_run_in_table: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, r_start} + {1'b0, r_len}) <= 12'(cpa_pkg::TABLE_PAGES))
    else $error("run reaches past the page table");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

endmodule

bind contiguous_page_allocator_clock_core cpa_checker u_cpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// Testbench for the contiguous page allocator with clock replacement.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic        mode;
    logic [21:0] byte_count;
    logic [9:0]  start_page;
    logic [10:0] page_count;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  run_start;
    logic [10:0] run_length;
    logic [10:0] evicted;
  } grant_t;

  // Pending-item kinds: a request, a pool write, or a drain point.
  typedef enum logic [1:0] {K_REQ, K_POOL, K_DRAIN} kind_t;

  typedef struct packed {
    kind_t       kind;
    request_t    req;
    logic [10:0] pool_val;
  } item_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [cpa_pkg::CNT_W-1:0] cfg_wdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [cpa_pkg::IN_W-1:0]  s_tdata;
  logic                      s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [cpa_pkg::OUT_W-1:0] m_tdata;

  contiguous_page_allocator_clock_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor state: a shadow of the page table and the allocator registers.
  logic        pg_free [cpa_pkg::TABLE_PAGES];
  logic        pg_ref  [cpa_pkg::TABLE_PAGES];
  int unsigned pool_reg;
  int unsigned free_pages;
  int unsigned hand;

  item_t  pending[$];
  grant_t expected_grants[$];
  int     errors;
  int     grants_seen;
  int     n_alloc_ok, n_evict, n_free;
  bit     no_idle;
  bit     stim_done;
  int     wait_cnt;

  function automatic int unsigned eff_pool();
    if (pool_reg == 0) return 1;
    if (pool_reg > cpa_pkg::TABLE_PAGES) return cpa_pkg::TABLE_PAGES;
    return pool_reg;
  endfunction

  // Sweep the clock hand for one victim; returns 1 if a page was reclaimed.
  function automatic bit sweep_victim(int unsigned pool);
    int unsigned h;
    int unsigned nxt;
    h = hand;
    if (h >= pool) h = 0;
    for (int unsigned s = 0; s < 2 * pool; s++) begin
      nxt = (h + 1 >= pool) ? 0 : h + 1;
      if (!pg_free[h]) begin
        if (!pg_ref[h]) begin
          pg_free[h] = 1'b1;
          hand = nxt;
          if (free_pages < pool) free_pages++;
          return 1'b1;
        end
        pg_ref[h] = 1'b0;
      end
      h = nxt;
    end
    hand = h;
    return 1'b0;
  endfunction

  // Compute the grant for one accepted request and update the shadow table.
  function automatic grant_t allocate_or_free(request_t r);
    grant_t      g;
    int unsigned pool;
    longint unsigned need;
    int unsigned added;
    int unsigned i;
    bit          found, run_ok;
    g = '0;
    pool = eff_pool();
    if (r.mode) begin
      added = 0;
      for (int unsigned k = 0; k < r.page_count; k++) begin
        if (r.start_page + k >= pool) break;
        pg_free[r.start_page + k] = 1'b1;
        pg_ref[r.start_page + k] = 1'b0;
        added++;
      end
      free_pages += added;
      if (free_pages > pool) free_pages = pool;
      n_free++;
    end else if (r.byte_count == 0) begin
      g.status = cpa_pkg::ST_ZERO;
    end else if (longint'(r.byte_count) >= longint'(pool) * cpa_pkg::PAGE_BYTES) begin
      g.status = cpa_pkg::ST_LARGE;
    end else begin
      need = (longint'(r.byte_count) + cpa_pkg::HEADER_BYTES + cpa_pkg::PAGE_BYTES - 1)
             / cpa_pkg::PAGE_BYTES;
      run_ok = 1'b1;
      while (need > free_pages) begin
        if (!sweep_victim(pool)) begin
          run_ok = 1'b0;
          break;
        end
        g.evicted++;
      end
      if (g.evicted != 0) n_evict++;
      if (!run_ok) begin
        g.status = cpa_pkg::ST_NO_VICTIM;
      end else begin
        found = 1'b0;
        for (i = 0; i + need <= pool; i++) begin
          found = 1'b1;
          for (int unsigned j = i; j < i + need; j++)
            if (!pg_free[j]) begin
              found = 1'b0;
              break;
            end
          if (found) break;
        end
        if (!found) begin
          g.status = cpa_pkg::ST_NO_RUN;
        end else begin
          for (int unsigned j = i; j < i + need; j++) begin
            pg_free[j] = 1'b0;
            pg_ref[j] = 1'b1;
          end
          free_pages = (free_pages >= need) ? free_pages - 32'(need) : 0;
          g.status = cpa_pkg::ST_OK;
          g.run_start = 10'(i);
          g.run_length = 11'(need);
          n_alloc_ok++;
        end
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on grant %0d: %s got %0d expected %0d", grants_seen, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold the run to a generous bound; slow allocations sweep the whole pool.
  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic item_t req_item(bit m, int unsigned b, int unsigned sp, int unsigned pc);
    item_t it;
    it = '0;
    it.kind = K_REQ;
    it.req.mode = m;
    it.req.byte_count = 22'(b);
    it.req.start_page = 10'(sp);
    it.req.page_count = 11'(pc);
    return it;
  endfunction

  function automatic item_t pool_item(int unsigned v);
    item_t it;
    it = '0;
    it.kind = K_POOL;
    it.pool_val = 11'(v);
    return it;
  endfunction

  function automatic item_t drain_item();
    item_t it;
    it = '0;
    it.kind = K_DRAIN;
    return it;
  endfunction

  // Fill the pending queue: directed corners, then random phases per pool size.
  initial begin
    int unsigned pools[6];
    int unsigned p, sz;
    pools = '{1024, 0, 2047, 1, 7, 40};
    pending.push_back(req_item(0, 0, 0, 0));           // zero size
    pending.push_back(req_item(0, 22'h3FFFFF, 0, 0));  // all bits set: under too large, over the pool
    pending.push_back(req_item(0, 1, 0, 0));
    pending.push_back(req_item(0, 4088, 0, 0));        // header fits one page
    pending.push_back(req_item(0, 4089, 0, 0));        // header spills to two
    pending.push_back(req_item(1, 0, 1, 1));
    pending.push_back(req_item(0, 4096 * 1000, 0, 0)); // large run, fits without clock eviction
    pending.push_back(req_item(0, 4096 * 1023 - 9, 0, 0));
    pending.push_back(req_item(1, 0, 1023, 1024));     // free clipped at pool end
    pending.push_back(req_item(1, 0, 0, 1024));
    pending.push_back(req_item(1, 0, 0, 0));
    pending.push_back(req_item(0, 4096 * 1024 - 1, 0, 0)); // just under too large
    pending.push_back(req_item(0, 4096 * 1024 - 9, 0, 0)); // needs whole pool
    pending.push_back(req_item(1, 0, 10, 4));          // fragment the pool
    pending.push_back(req_item(0, 4096 * 8, 0, 0));    // no contiguous run
    pending.push_back(req_item(1, 0, 5, 2000));
    pending.push_back(req_item(1, 0, 5, 2000));        // saturating repeat free
    for (int ph = 0; ph < 6; ph++) begin
      pending.push_back(drain_item());
      pending.push_back(pool_item(pools[ph]));
      p = (pools[ph] == 0) ? 1 : (pools[ph] > 1024 ? 1024 : pools[ph]);
      for (int k = 0; k < 46; k++) begin
        if ($urandom_range(0, 99) < 60) begin
          case ($urandom_range(0, 9))
            0: pending.push_back(req_item(0, $urandom, 0, 0));
            1: pending.push_back(req_item(0, 0, $urandom, $urandom));
            default: begin
              sz = (ph == 0 && $urandom_range(0, 9) == 0) ? p : ((p < 8) ? p : 8);
              pending.push_back(req_item(0, $urandom_range(1, sz * cpa_pkg::PAGE_BYTES - 1),
                                         $urandom, $urandom));
            end
          endcase
        end else begin
          pending.push_back(req_item(1, $urandom, $urandom_range(0, p - 1),
                                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                                : $urandom_range(0, 6)));
        end
        if (ph == 2 && k == 20) pending.push_back(drain_item());
      end
    end
  end

  // Driver: pop pending items, write the pool register only when drained.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      cfg_we   <= 1'b0;
      cfg_wdata <= '0;
      wait_cnt <= 0;
    end else begin
      cfg_we <= 1'b0;
      if (s_tvalid && !s_tready) begin
        // hold the request until it is taken
      end else if (pending.size() == 0) begin
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending[0].kind != K_REQ) begin
        s_tvalid <= 1'b0;
        // Drain, then let the block settle before touching the register.
        if (expected_grants.size() != 0 || s_tvalid) begin
          wait_cnt <= 0;
        end else if (wait_cnt < 8200) begin
          wait_cnt <= wait_cnt + 1;
        end else begin
          if (pending[0].kind == K_POOL) begin
            cfg_we <= 1'b1;
            cfg_wdata <= pending[0].pool_val;
            pool_reg = pending[0].pool_val;
          end
          void'(pending.pop_front());
          wait_cnt <= 0;
        end
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= cpa_pkg::IN_W'({pending[0].req.page_count, pending[0].req.start_page,
                                    pending[0].req.byte_count});
        s_tuser  <= pending[0].req.mode;
        void'(pending.pop_front());
      end
    end
  end

  // Predict at acceptance so the order of grants follows the order of requests.
  always @(posedge clk) begin
    request_t r;
    if (!rst && s_tvalid && s_tready) begin
      r.mode = s_tuser;
      r.byte_count = s_tdata[21:0];
      r.start_page = s_tdata[31:22];
      r.page_count = s_tdata[42:32];
      expected_grants.push_back(allocate_or_free(r));
    end
  end

  // Monitor: check each grant against the oldest expectation; stall at random.
  always @(posedge clk) begin
    grant_t g, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        g.status     = m_tdata[2:0];
        g.run_start  = m_tdata[12:3];
        g.run_length = m_tdata[23:13];
        g.evicted    = m_tdata[34:24];
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected grant status", g.status, 0);
        end else begin
          want = expected_grants.pop_front();
          if (g.status != want.status) report_mismatch("status", g.status, want.status);
          if (g.run_start != want.run_start)
            report_mismatch("run_start", g.run_start, want.run_start);
          if (g.run_length != want.run_length)
            report_mismatch("run_length", g.run_length, want.run_length);
          if (g.evicted != want.evicted) report_mismatch("evicted", g.evicted, want.evicted);
        end
        grants_seen++;
      end
      m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  initial begin
    int unsigned settle;
    errors = 0;
    grants_seen = 0;
    n_alloc_ok = 0;
    n_evict = 0;
    n_free = 0;
    no_idle = 1'b0;
    stim_done = 1'b0;
    pool_reg = 1024;
    free_pages = cpa_pkg::TABLE_PAGES;
    hand = 0;
    for (int k = 0; k < cpa_pkg::TABLE_PAGES; k++) begin
      pg_free[k] = 1'b1;
      pg_ref[k] = 1'b0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Run a stretch with no idling on either side in the middle of the run.
    wait (pending.size() < 150);
    no_idle = 1'b1;
    wait (pending.size() < 110);
    no_idle = 1'b0;
    wait (stim_done && expected_grants.size() == 0);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    $display("covered %0d grants: %0d runs claimed, %0d with clock evictions, %0d frees",
             grants_seen, n_alloc_ok, n_evict, n_free);
    $display("pool sizes swept from 1 page to the full table, including out-of-range writes");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
